[hw/rtl/slm_pkg.sv]
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants for the sorted list merge block
// Command codes, result kinds and the command queue entry format.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned SLM_LIST_DEPTH     = 32;
  localparam int unsigned SLM_CMD_FIFO_DEPTH = 2;
  localparam int unsigned SLM_CMD_W          = 2;
  localparam int unsigned SLM_VALUE_W        = 32;
  localparam int unsigned SLM_KIND_W         = 2;

  typedef enum logic [SLM_CMD_W-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2
  } slm_cmd_e;

  typedef enum logic [SLM_KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_MERGED   = 2'd2,
    KIND_EMPTY    = 2'd3
  } slm_kind_e;

  typedef struct packed {
    slm_cmd_e                       op;
    logic signed [SLM_VALUE_W-1:0] value;
  } slm_cmd_t;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic     valid;
    slm_cmd_t cmd;
  } slm_q_out_t;

endpackage

[hw/rtl/slm_front.sv]
// ----------------------------------------------------------------------------
// slm_front: input stage
// Accepts input items, drops unused command codes and holds one classified
// command until the command queue can take it.
// ----------------------------------------------------------------------------
module slm_front import slm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [SLM_CMD_W-1:0]          cmd_i,
  input  logic signed [SLM_VALUE_W-1:0] value_i,
  output logic                          q_push_o,
  output slm_cmd_t                      q_cmd_o,
  input  logic                          q_full_i
);

  logic     valid_q, valid_d;
  slm_cmd_t cmd_q, cmd_d;
  logic     accept, drain, known;

  assign drain  = valid_q && !q_full_i;
  assign full   = valid_q && q_full_i;
  assign accept = push && !full;
  assign known  = cmd_i inside {CMD_APPEND_A, CMD_APPEND_B, CMD_MERGE};

  always_comb begin
    valid_d = valid_q && !drain;
    cmd_d   = cmd_q;
    // An item with an unused command code is taken and produces nothing.
    if (accept && known) begin
      valid_d      = 1'b1;
      cmd_d.op     = slm_cmd_e'(cmd_i);
      cmd_d.value  = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign q_push_o = valid_q;
  assign q_cmd_o  = cmd_q;

endmodule

[hw/rtl/slm_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// slm_cmd_fifo: command queue
// Short first-in first-out queue between the front stage and the back end.
// ----------------------------------------------------------------------------
module slm_cmd_fifo import slm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  slm_cmd_t   cmd_i,
  output logic       full_o,
  output slm_q_out_t head_o,
  input  logic       pop_i
);

  localparam int unsigned Depth = SLM_CMD_FIFO_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  slm_cmd_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hw/rtl/slm_back.sv]
// ----------------------------------------------------------------------------
// slm_back: execution back end
// Owns both list stores, executes appends and walks both lists during a
// merge, one result per cycle into the result register while it is free or popped.
// ----------------------------------------------------------------------------
module slm_back import slm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = SLM_LIST_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slm_q_out_t                    head_i,
  output logic                          q_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [SLM_KIND_W-1:0]         kind_o,
  output logic signed [SLM_VALUE_W-1:0] value_res_o,
  output logic                          last_o
);

  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               count_a_q, count_a_d, count_b_q, count_b_d;
  logic [CntW-1:0]               ia_q, ia_d, ib_q, ib_d;
  logic                          out_valid_q, out_valid_d;
  slm_kind_e                     out_kind_q, out_kind_d;
  logic signed [SLM_VALUE_W-1:0] out_value_q, out_value_d;
  logic                          out_last_q, out_last_d;

  logic signed [SLM_VALUE_W-1:0] mem_a [LIST_DEPTH];
  logic signed [SLM_VALUE_W-1:0] mem_b [LIST_DEPTH];
  logic signed [SLM_VALUE_W-1:0] rda_q, rdb_q;
  logic [IdxW-1:0]               raddr_a, raddr_b;
  logic                          we_a, we_b;

  logic                          out_ready, a_avail, b_avail, take_a, take_b, is_last;
  logic [CntW:0]                 emitted, total;

  assign out_ready = !out_valid_q || pop;
  assign a_avail   = (ia_q < count_a_q);
  assign b_avail   = (ib_q < count_b_q);
  // Ties go to list A, which keeps the merge stable.
  assign take_a    = a_avail && (!b_avail || (rda_q <= rdb_q));
  assign take_b    = !take_a && b_avail;
  assign emitted   = {1'b0, ia_q} + {1'b0, ib_q} + 1'b1;
  assign total     = {1'b0, count_a_q} + {1'b0, count_b_q};
  assign is_last   = (emitted == total);

  always_comb begin
    state_d     = state_q;
    count_a_d   = count_a_q;
    count_b_d   = count_b_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    out_valid_d = out_valid_q && !pop;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        ia_d = '0;
        ib_d = '0;
        if (head_i.valid && out_ready) begin
          q_pop_o     = 1'b1;
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_last_d  = 1'b1;
          case (head_i.cmd.op)
            CMD_APPEND_A: begin
              if (count_a_q < CntW'(LIST_DEPTH)) begin
                we_a       = 1'b1;
                count_a_d  = count_a_q + 1'b1;
                out_kind_d = KIND_ACCEPTED;
              end else begin
                out_kind_d = KIND_FULL;
              end
            end
            CMD_APPEND_B: begin
              if (count_b_q < CntW'(LIST_DEPTH)) begin
                we_b       = 1'b1;
                count_b_d  = count_b_q + 1'b1;
                out_kind_d = KIND_ACCEPTED;
              end else begin
                out_kind_d = KIND_FULL;
              end
            end
            CMD_MERGE: begin
              if (total == '0) begin
                out_kind_d = KIND_EMPTY;
              end else begin
                // The first heads are read this cycle; results start in ST_MERGE once the result register is free.
                out_valid_d = out_valid_q && !pop;
                state_d     = ST_MERGE;
              end
            end
            default: begin
              out_valid_d = out_valid_q && !pop;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_MERGED;
          out_value_d = take_a ? rda_q : rdb_q;
          out_last_d  = is_last;
          ia_d        = ia_q + CntW'(take_a);
          ib_d        = ib_q + CntW'(take_b);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read the next head every cycle; a stalled merge simply rereads the same entry.
  assign raddr_a = (ia_d < CntW'(LIST_DEPTH)) ? ia_d[IdxW-1:0] : '0;
  assign raddr_b = (ib_d < CntW'(LIST_DEPTH)) ? ib_d[IdxW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[count_a_q[IdxW-1:0]] <= head_i.cmd.value;
    end
    rda_q <= mem_a[raddr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[count_b_q[IdxW-1:0]] <= head_i.cmd.value;
    end
    rdb_q <= mem_b[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_a_q   <= '0;
      count_b_q   <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_ACCEPTED;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_a_q   <= count_a_d;
      count_b_q   <= count_b_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_value_q <= out_value_d;
      out_last_q  <= out_last_d;
    end
  end

  assign empty       = !out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_res_o = out_value_q;
  assign last_o      = out_last_q;

  a_merge_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (ia_q <= count_a_q) && (ib_q <= count_b_q) &&
                              (ia_q + ib_q < total))
    else $error("merge indices ran past the list lengths");

  a_merge_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (total != '0))
    else $error("merge running with both lists empty");

  a_merge_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && out_ready && is_last) |=> (state_q == ST_IDLE))
    else $error("merge did not end after its last result");

  a_counts_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |=> $stable(count_a_q) && $stable(count_b_q))
    else $error("list length changed during a merge");

endmodule

[hw/rtl/sorted_list_merge.sv]
// ----------------------------------------------------------------------------
// sorted_list_merge: two append-built lists merged into one ascending stream
// Top level: front stage, command queue and execution back end.
// ----------------------------------------------------------------------------
// An append answers with one result, so appends flow at one per cycle while
// the result register is free or popped. A merge occupies the back end: it
// first reads the heads of both lists, then gives one result per cycle while
// the result register is free or popped, paced by the single read port of
// each list store. A merge of two empty lists answers with one result.
// Commands queue up behind a merge in the front stage and the command queue
// (three commands deep) before full rises. Results stall the back end only
// while the result register is occupied and not popped.
module sorted_list_merge import slm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = SLM_LIST_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [SLM_CMD_W-1:0]          cmd_i,
  input  logic signed [SLM_VALUE_W-1:0] value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [SLM_KIND_W-1:0]         kind_o,
  output logic signed [SLM_VALUE_W-1:0] value_res_o,
  output logic                          last_o
);

  logic       q_push, q_full, q_pop;
  slm_cmd_t   q_cmd;
  slm_q_out_t q_head;

  slm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .cmd_i    (cmd_i),
    .value_i  (value_i),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd),
    .q_full_i (q_full)
  );

  slm_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  slm_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .value_res_o (value_res_o),
    .last_o      (last_o)
  );

endmodule
